// ----- sv/rntd_pkg.sv -----
`timescale 1ns / 1ps

package rntd_pkg;

    localparam int INT_WIDTH       = 31;
    localparam int FRAC_WIDTH      = 32;
    localparam int MAX_FRAC_DIGITS = 10;
    localparam int STACK_DEPTH     = 32;

    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 8;
    localparam int DIV_CHUNK = 8;
    localparam int DIV_STEPS = (INT_WIDTH + DIV_CHUNK - 1) / DIV_CHUNK;
    localparam int DIV_WIDTH = DIV_STEPS * DIV_CHUNK;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int ADDR_W    = $clog2(STACK_DEPTH);
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int FCNT_W    = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int PROD_W    = FRAC_WIDTH + RADIX_W;

    localparam longint unsigned FRAC_EPS =
        ((64'd1 << FRAC_WIDTH) - 64'd1) / 64'd100000000;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_SEP  = 8'h2C;

    typedef struct packed {
        logic [INT_WIDTH-1:0]  int_part;
        logic [FRAC_WIDTH-1:0] frac_part;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic pop;
        logic emit_digit;
        logic emit_sep;
        logic emit_frac;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic cnt_zero;
        logic slot_free;
        logic frac_done;
    } status_t;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10))
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_W'(d - DIGIT_W'(10));
        end
        return c;
    endfunction

endpackage

// ----- sv/rntd_ram.sv -----
`timescale 1ns / 1ps

module rntd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/rntd_ctrl.sv -----
`timescale 1ns / 1ps

module rntd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rntd_pkg::status_t  st,
    output rntd_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DIV     = 6'b000010,
        ST_POP_RD  = 6'b000100,
        ST_POP_OUT = 6'b001000,
        ST_SEP     = 6'b010000,
        ST_FRAC    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    cmd.push = 1'b1;
                    if (st.quot_zero)
                    begin
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_POP_RD:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_POP_OUT;
            end
            ST_POP_OUT:
            begin
                if (st.slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    state_next     = st.cnt_zero ? ST_SEP : ST_POP_RD;
                end
            end
            ST_SEP:
            begin
                if (st.slot_free)
                begin
                    cmd.emit_sep = 1'b1;
                    state_next   = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (st.slot_free)
                begin
                    cmd.emit_frac = 1'b1;
                    if (st.frac_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DIV))
        else $error("accepted item did not start the division");

    a_frac_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_frac && st.frac_done) |=> (state_reg == ST_IDLE))
        else $error("final character did not return to idle");

endmodule

// ----- sv/rntd_dpath.sv -----
`timescale 1ns / 1ps

module rntd_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rntd_pkg::in_item_t                in_data,
    input  logic                              cfg_valid,
    input  logic [rntd_pkg::RADIX_W-1:0]      cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output rntd_pkg::out_item_t               out_data,
    input  rntd_pkg::cmd_t                    cmd,
    output rntd_pkg::status_t                 st
);

    logic [rntd_pkg::RADIX_W-1:0]   radix_reg;
    logic [rntd_pkg::RADIX_W-1:0]   radix_eff_reg;
    logic [rntd_pkg::RADIX_W-1:0]   radix_clamped;
    logic [rntd_pkg::DIV_WIDTH-1:0] div_reg;
    logic [rntd_pkg::DIV_WIDTH-1:0] div_next;
    logic [rntd_pkg::DIGIT_W-1:0]   rem_reg;
    logic [rntd_pkg::DIGIT_W-1:0]   rem_next;
    logic [rntd_pkg::STEP_W-1:0]    step_reg;
    logic [rntd_pkg::CNT_W-1:0]     cnt_reg;
    logic [rntd_pkg::CNT_W-1:0]     cnt_dec;
    logic [rntd_pkg::FRAC_WIDTH-1:0] frac_reg;
    logic [rntd_pkg::FCNT_W-1:0]    fcnt_reg;
    logic [rntd_pkg::PROD_W-1:0]    prod;
    logic [rntd_pkg::DIGIT_W-1:0]   frac_digit;
    logic [rntd_pkg::FRAC_WIDTH-1:0] frac_rest;
    logic                           push_ok;
    logic [rntd_pkg::DIGIT_W-1:0]   stack_rdata;
    logic                           out_valid_reg;
    rntd_pkg::out_item_t            out_reg;

    // config register, raw bits kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rntd_pkg::RADIX_RESET;
        end
        else if (cfg_valid)
        begin
            radix_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (radix_reg < rntd_pkg::RADIX_MIN)
        begin
            radix_clamped = rntd_pkg::RADIX_MIN;
        end
        else if (radix_reg > rntd_pkg::RADIX_MAX)
        begin
            radix_clamped = rntd_pkg::RADIX_MAX;
        end
        else
        begin
            radix_clamped = radix_reg;
        end
    end

    // one chunk of long division by the radix per cycle
    always_comb
    begin
        logic [rntd_pkg::DIV_CHUNK-1:0] top;
        logic [rntd_pkg::DIV_CHUNK-1:0] qbits;
        logic [rntd_pkg::DIGIT_W-1:0]   r;
        logic [rntd_pkg::DIGIT_W:0]     t;
        top   = div_reg[rntd_pkg::DIV_WIDTH-1 -: rntd_pkg::DIV_CHUNK];
        qbits = '0;
        r     = rem_reg;
        for (int i = rntd_pkg::DIV_CHUNK - 1; i >= 0; i--)
        begin
            t = {r, top[i]};
            if (t >= radix_eff_reg)
            begin
                t        = t - radix_eff_reg;
                qbits[i] = 1'b1;
            end
            r = t[rntd_pkg::DIGIT_W-1:0];
        end
        rem_next = r;
        div_next = {div_reg[rntd_pkg::DIV_WIDTH-rntd_pkg::DIV_CHUNK-1:0], qbits};
    end

    assign cnt_dec = cnt_reg - 1'b1;
    assign push_ok = cmd.push && (cnt_reg < rntd_pkg::CNT_W'(rntd_pkg::STACK_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            cnt_reg  <= '0;
            fcnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            step_reg <= '0;
            cnt_reg  <= '0;
            fcnt_reg <= '0;
        end
        else
        begin
            if (cmd.div_step)
            begin
                step_reg <= cmd.push ? '0 : step_reg + 1'b1;
            end
            if (push_ok)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                cnt_reg <= cnt_dec;
            end
            if (cmd.emit_frac)
            begin
                fcnt_reg <= fcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            radix_eff_reg <= radix_clamped;
            div_reg       <= rntd_pkg::DIV_WIDTH'(in_data.int_part);
            rem_reg       <= '0;
            frac_reg      <= in_data.frac_part;
        end
        else
        begin
            if (cmd.div_step)
            begin
                div_reg <= div_next;
                rem_reg <= cmd.push ? '0 : rem_next;
            end
            if (cmd.emit_frac)
            begin
                frac_reg <= frac_rest;
            end
        end
    end

    rntd_ram #(
        .WIDTH (rntd_pkg::DIGIT_W),
        .DEPTH (rntd_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (push_ok),
        .waddr (cnt_reg[rntd_pkg::ADDR_W-1:0]),
        .wdata (rem_next),
        .re    (cmd.pop),
        .raddr (cnt_dec[rntd_pkg::ADDR_W-1:0]),
        .rdata (stack_rdata)
    );

    // fraction digit: multiply by radix, digit leaves past the binary point
    assign prod       = rntd_pkg::PROD_W'(frac_reg) * rntd_pkg::PROD_W'(radix_eff_reg);
    assign frac_digit = prod[rntd_pkg::FRAC_WIDTH +: rntd_pkg::DIGIT_W];
    assign frac_rest  = prod[rntd_pkg::FRAC_WIDTH-1:0];

    assign st.div_last  = (step_reg == rntd_pkg::STEP_W'(rntd_pkg::DIV_STEPS - 1));
    assign st.quot_zero = (div_next == '0);
    assign st.cnt_zero  = (cnt_reg == '0);
    assign st.slot_free = !out_valid_reg || out_ready;
    assign st.frac_done = (frac_rest <= rntd_pkg::FRAC_WIDTH'(rntd_pkg::FRAC_EPS))
                       || (fcnt_reg == rntd_pkg::FCNT_W'(rntd_pkg::MAX_FRAC_DIGITS - 1));

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_digit || cmd.emit_sep || cmd.emit_frac)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_digit)
        begin
            out_reg.out_char <= rntd_pkg::to_ascii(stack_rdata);
            out_reg.last     <= 1'b0;
        end
        else if (cmd.emit_sep)
        begin
            out_reg.out_char <= rntd_pkg::CHAR_SEP;
            out_reg.last     <= 1'b0;
        end
        else if (cmd.emit_frac)
        begin
            out_reg.out_char <= rntd_pkg::to_ascii(frac_digit);
            out_reg.last     <= st.frac_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (cnt_reg != '0))
        else $error("digit stack popped while empty");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= rntd_pkg::CNT_W'(rntd_pkg::STACK_DEPTH))
        else $error("digit count beyond stack depth");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit || cmd.emit_sep || cmd.emit_frac) |-> st.slot_free)
        else $error("character overwrote a pending transfer");

endmodule

// ----- sv/radix_number_to_digits.sv -----
`timescale 1ns / 1ps

// Converts an unsigned integer part and a 0.32 fraction to ASCII digits in the
// radix held by the configuration register (values below 2 act as 2, above 16
// as 16), sending the integer digits most significant first, a comma, then one
// to ten fraction digits, with last set on the final character. One number is
// converted at a time. Each integer digit comes from a full pass of the long
// divider, which takes eight dividend bits a cycle, and then passes through the
// digit stack, whose read is registered, in a read state and an output state;
// each fraction digit comes from one multiply by the radix. A new number is
// taken once the last character of the previous one sits in the output
// register.
module radix_number_to_digits (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rntd_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rntd_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rntd_pkg::RADIX_W-1:0]  cfg_data
);

    rntd_pkg::cmd_t    cmd;
    rntd_pkg::status_t st;

    assign cfg_ready = 1'b1;

    rntd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    rntd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
